// ----- hdl/rpt_pkg.sv -----
// Package for the rain period totalizer.
// Holds the record codes, register indexes, walk state and threshold types.
// No dependencies.
package rpt_pkg;

	localparam int RAIN_W  = 16;
	localparam int MIN_W   = 16;
	localparam int INTV_W  = 8;
	localparam int IDX_W   = 2;
	localparam int NPER    = 4;

	localparam logic [INTV_W-1:0] INTERVAL_INVALID = 8'hFF;
	localparam logic [RAIN_W-1:0] RAIN_INVALID     = 16'hFFFF;

	localparam int P_HOUR  = 0;
	localparam int P_DAY   = 1;
	localparam int P_WEEK  = 2;
	localparam int P_MONTH = 3;

	localparam logic [IDX_W-1:0] REG_HOUR  = 2'd0;
	localparam logic [IDX_W-1:0] REG_DAY   = 2'd1;
	localparam logic [IDX_W-1:0] REG_WEEK  = 2'd2;
	localparam logic [IDX_W-1:0] REG_MONTH = 2'd3;

	localparam logic [MIN_W-1:0] HOUR_RESET  = 16'd60;
	localparam logic [MIN_W-1:0] DAY_RESET   = 16'd1440;
	localparam logic [MIN_W-1:0] WEEK_RESET  = 16'd10080;
	localparam logic [MIN_W-1:0] MONTH_RESET = 16'd43200;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef struct packed {
		logic [RAIN_W-1:0]            newest;
		logic [MIN_W-1:0]             elapsed;
		logic [2:0]                   done;
		logic [NPER-1:0][RAIN_W-1:0]  totals;
		logic                         active;
	} walk_t;

	typedef struct packed {
		logic [MIN_W-1:0] hour;
		logic [MIN_W-1:0] day;
		logic [MIN_W-1:0] week;
		logic [MIN_W-1:0] month;
	} thresh_t;

	typedef struct packed {
		logic [INTV_W-1:0] interval;
		logic [RAIN_W-1:0] rain;
		logic              first;
		logic              last;
	} record_t;

	typedef struct packed {
		logic emit;
		logic status;
	} step_res_t;

endpackage

// ----- hdl/rpt_step.sv -----
// Per-record update of the walk state: threshold checks, period take, elapsed add.
// Purely combinational; uses rpt_pkg.
module rpt_step import rpt_pkg::*; (
	input  walk_t     cur,
	input  thresh_t   thr,
	input  record_t   rec,
	output walk_t     nxt,
	output step_res_t res
);

	walk_t             eff;
	logic              rain_ok;
	logic [RAIN_W-1:0] diff;

	always_comb begin
		eff = cur;
		if (rec.first) begin
			eff.newest  = rec.rain;
			eff.elapsed = '0;
			eff.done    = '0;
			eff.totals  = '0;
			eff.active  = 1'b1;
		end

		rain_ok = (rec.rain != RAIN_INVALID) && (eff.newest != RAIN_INVALID);
		diff    = eff.newest - rec.rain;

		nxt        = eff;
		res.emit   = 1'b0;
		res.status = STATUS_OK;

		if (eff.active) begin
			if (rec.interval == INTERVAL_INVALID) begin
				res.emit   = 1'b1;
				res.status = STATUS_INVALID;
				nxt.active = 1'b0;
			end else if (eff.elapsed >= thr.month) begin
				if (rain_ok) begin
					nxt.totals[P_MONTH] = diff;
				end
				res.emit   = 1'b1;
				nxt.active = 1'b0;
			end else begin
				if (!eff.done[P_WEEK] && eff.elapsed >= thr.week) begin
					if (rain_ok) begin
						nxt.totals[P_WEEK] = diff;
					end
					nxt.done[P_WEEK] = 1'b1;
				end else if (!eff.done[P_DAY] && eff.elapsed >= thr.day) begin
					if (rain_ok) begin
						nxt.totals[P_DAY] = diff;
					end
					nxt.done[P_DAY] = 1'b1;
				end else if (!eff.done[P_HOUR] && eff.elapsed >= thr.hour) begin
					if (rain_ok) begin
						nxt.totals[P_HOUR] = diff;
					end
					nxt.done[P_HOUR] = 1'b1;
				end
				nxt.elapsed = eff.elapsed + {{(MIN_W-INTV_W){1'b0}}, rec.interval};
				if (rec.last) begin
					res.emit   = 1'b1;
					nxt.active = 1'b0;
				end
			end
		end
	end

endmodule

// ----- hdl/rain_period_totalizer.sv -----
// Top level of the rain period totalizer: input stage, walk state, result register.
// Uses rpt_pkg and rpt_step.
//
// channel  direction  handshake            payload
// in       sink       in_valid/in_stall    interval_minutes rain_counter first_record last_record
// out      source     out_valid/out_stall  rain_hour rain_day rain_week rain_month walk_status
// config   sink       wr_en                wr_index wr_data
//
// One record per cycle while in_stall is low; a record is registered, then its
// compare and subtract against the walk state update the state and the result
// register when the output is free.
// Reset clears the walk state and loads the default thresholds.
// in_stall rises only while a record waits in the input stage and the result register
// is full and stalled.
module rain_period_totalizer import rpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [INTV_W-1:0]  interval_minutes,
	input  logic [RAIN_W-1:0]  rain_counter,
	input  logic               first_record,
	input  logic               last_record,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [RAIN_W-1:0]  rain_hour,
	output logic [RAIN_W-1:0]  rain_day,
	output logic [RAIN_W-1:0]  rain_week,
	output logic [RAIN_W-1:0]  rain_month,
	output logic               walk_status,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [MIN_W-1:0]   wr_data
);

	thresh_t   thr_q;
	walk_t     walk_q;
	walk_t     walk_nxt;
	record_t   rec_s1;
	logic      valid_s1;
	step_res_t res;
	logic      out_free;
	logic      adv;
	logic      in_xfer;

	logic [NPER-1:0][RAIN_W-1:0] totals_q;
	logic                        status_q;
	logic                        out_valid_q;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	rpt_step u_step (
		.cur (walk_q),
		.thr (thr_q),
		.rec (rec_s1),
		.nxt (walk_nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.hour  <= HOUR_RESET;
			thr_q.day   <= DAY_RESET;
			thr_q.week  <= WEEK_RESET;
			thr_q.month <= MONTH_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_HOUR:  thr_q.hour  <= wr_data;
				REG_DAY:   thr_q.day   <= wr_data;
				REG_WEEK:  thr_q.week  <= wr_data;
				REG_MONTH: thr_q.month <= wr_data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rec_s1.interval <= interval_minutes;
			rec_s1.rain     <= rain_counter;
			rec_s1.first    <= first_record;
			rec_s1.last     <= last_record;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (adv) begin
			walk_q <= walk_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			totals_q <= walk_nxt.totals;
			status_q <= res.status;
		end
	end

	assign out_valid   = out_valid_q;
	assign rain_hour   = totals_q[P_HOUR];
	assign rain_day    = totals_q[P_DAY];
	assign rain_week   = totals_q[P_WEEK];
	assign rain_month  = totals_q[P_MONTH];
	assign walk_status = status_q;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_emit_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.emit) |=> (!walk_q.active && out_valid_q))
		else $error("walk still active after its result");

	a_first_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && rec_s1.first && !res.emit) |=> (walk_q.active && walk_q.newest == $past(rec_s1.rain)))
		else $error("first record did not start a walk");
`endif

endmodule

// ----- tb/sv/rain_period_totalizer_tb.sv -----
`timescale 1ns / 100ps
// Testbench for rain_period_totalizer: directed and random record walks with a
// record-level predictor of the window totals, random bursts, stalls and backpressure.
// Depends on rpt_pkg and the rain_period_totalizer RTL.
module rain_period_totalizer_tb;
	import rpt_pkg::*;

	typedef struct packed {
		logic [RAIN_W-1:0] hour;
		logic [RAIN_W-1:0] day;
		logic [RAIN_W-1:0] week;
		logic [RAIN_W-1:0] month;
		logic              status;
	} rain_totals_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [INTV_W-1:0] interval_minutes = '0;
	logic [RAIN_W-1:0] rain_counter = '0;
	logic              first_record = 1'b0;
	logic              last_record = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [RAIN_W-1:0] rain_hour;
	logic [RAIN_W-1:0] rain_day;
	logic [RAIN_W-1:0] rain_week;
	logic [RAIN_W-1:0] rain_month;
	logic              walk_status;
	logic              wr_en = 1'b0;
	logic [IDX_W-1:0]  wr_index = '0;
	logic [MIN_W-1:0]  wr_data = '0;

	rain_totals_t pending_totals[$];
	rain_totals_t got_totals;
	rain_totals_t want_totals;
	walk_t        walk;
	thresh_t      windows;
	int           errors_seen = 0;
	int           records_walked = 0;
	int           burst_left = 0;
	int           gap_max = 5;
	int           interval_max = 254;
	int           hold_request = 0;
	int           hold_left = 0;
	int           pattern_left = 0;
	int           stall_pct = 0;

	rain_period_totalizer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.interval_minutes(interval_minutes), .rain_counter(rain_counter),
		.first_record(first_record), .last_record(last_record),
		.out_valid(out_valid), .out_stall(out_stall),
		.rain_hour(rain_hour), .rain_day(rain_day), .rain_week(rain_week),
		.rain_month(rain_month), .walk_status(walk_status),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #1 clk = ~clk;

	initial begin
		#400_000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver: random stall pattern, long hold-off on request
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (pattern_left == 0) begin
			pattern_left = $urandom_range(20, 80);
			case ($urandom_range(0, 4))
				0, 1: stall_pct = 0;
				2: stall_pct = 20;
				3: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		pattern_left--;
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	function automatic void check_field(string name, logic [RAIN_W-1:0] want,
			logic [RAIN_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors_seen++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_totals = '{rain_hour, rain_day, rain_week, rain_month, walk_status};
			if (pending_totals.size() == 0) begin
				$error("result transfer with no walk result pending");
				errors_seen++;
			end else begin
				want_totals = pending_totals.pop_front();
				check_field("rain_hour", want_totals.hour, got_totals.hour);
				check_field("rain_day", want_totals.day, got_totals.day);
				check_field("rain_week", want_totals.week, got_totals.week);
				check_field("rain_month", want_totals.month, got_totals.month);
				check_field("walk_status", want_totals.status, got_totals.status);
			end
		end
	end

	task automatic close_walk(logic status);
		pending_totals.push_back('{walk.totals[P_HOUR], walk.totals[P_DAY],
			walk.totals[P_WEEK], walk.totals[P_MONTH], status});
		walk.active = 1'b0;
	endtask

	task automatic take_window(int idx, logic [RAIN_W-1:0] rain);
		if (rain != RAIN_INVALID && walk.newest != RAIN_INVALID)
			walk.totals[idx] = walk.newest - rain;
	endtask

	task automatic advance_walk(record_t rec);
		if (rec.first) begin
			walk = '0;
			walk.newest = rec.rain;
			walk.active = 1'b1;
		end
		if (!walk.active)
			return;
		records_walked++;
		if (rec.interval == INTERVAL_INVALID) begin
			close_walk(STATUS_INVALID);
			return;
		end
		if (walk.elapsed >= windows.month) begin
			take_window(P_MONTH, rec.rain);
			close_walk(STATUS_OK);
			return;
		end else if (!walk.done[2] && walk.elapsed >= windows.week) begin
			take_window(P_WEEK, rec.rain);
			walk.done[2] = 1'b1;
		end else if (!walk.done[1] && walk.elapsed >= windows.day) begin
			take_window(P_DAY, rec.rain);
			walk.done[1] = 1'b1;
		end else if (!walk.done[0] && walk.elapsed >= windows.hour) begin
			take_window(P_HOUR, rec.rain);
			walk.done[0] = 1'b1;
		end
		walk.elapsed = walk.elapsed + MIN_W'(rec.interval);
		if (rec.last)
			close_walk(STATUS_OK);
	endtask

	task automatic send_record(record_t rec);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		interval_minutes <= rec.interval;
		rain_counter <= rec.rain;
		first_record <= rec.first;
		last_record <= rec.last;
		do @(posedge clk); while (in_stall);
		advance_walk(rec);
	endtask

	task automatic send(logic [INTV_W-1:0] intv, logic [RAIN_W-1:0] rain,
			logic first, logic last);
		send_record('{intv, rain, first, last});
	endtask

	task automatic wait_idle();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_threshold(logic [IDX_W-1:0] idx, logic [MIN_W-1:0] value);
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk) wr_en <= 1'b0;
		case (idx)
			REG_HOUR: windows.hour = value;
			REG_DAY: windows.day = value;
			REG_WEEK: windows.week = value;
			REG_MONTH: windows.month = value;
			default: ;
		endcase
	endtask

	task automatic set_windows(int hour, int day, int week, int month);
		set_threshold(REG_HOUR, MIN_W'(hour));
		set_threshold(REG_DAY, MIN_W'(day));
		set_threshold(REG_WEEK, MIN_W'(week));
		set_threshold(REG_MONTH, MIN_W'(month));
	endtask

	function automatic logic [INTV_W-1:0] pick_interval();
		case ($urandom_range(0, 19))
			0: return INTERVAL_INVALID;
			1: return '0;
			2: return 8'd254;
			default: return INTV_W'($urandom_range(1, interval_max));
		endcase
	endfunction

	// one walk of len records, newest first, with occasional broken structure
	task automatic send_walk(int len);
		record_t           rec;
		logic [RAIN_W-1:0] rain_now;
		if ($urandom_range(0, 19) == 0)
			send(pick_interval(), RAIN_W'($urandom_range(0, 65535)), 1'b0,
				1'($urandom_range(0, 1)));
		rain_now = ($urandom_range(0, 19) == 0) ? RAIN_INVALID
			: RAIN_W'($urandom_range(0, 65535));
		for (int i = 0; i < len; i++) begin
			rec.first = (i == 0) || ($urandom_range(0, 39) == 0);
			rec.last = (i == len - 1) || ($urandom_range(0, 39) == 0);
			rec.interval = pick_interval();
			if (i != 0)
				rain_now = rain_now - RAIN_W'($urandom_range(0, 50));
			case ($urandom_range(0, 24))
				0: rec.rain = RAIN_INVALID;
				1: rec.rain = RAIN_W'($urandom_range(0, 65535));
				default: rec.rain = rain_now;
			endcase
			send_record(rec);
		end
	endtask

	task automatic test_directed();
		send(8'd0, 16'd0, 1'b1, 1'b1);
		send(INTERVAL_INVALID, RAIN_INVALID, 1'b1, 1'b0);
		send(8'd10, 16'd500, 1'b0, 1'b1);
		send(8'd254, RAIN_INVALID, 1'b1, 1'b1);
		send(8'd60, 16'd1000, 1'b1, 1'b0);
		send(8'd0, 16'd900, 1'b0, 1'b0);
		send(8'd254, 16'd800, 1'b0, 1'b1);
		send(8'd5, 16'd2000, 1'b1, 1'b0);
		send(8'd5, 16'd1990, 1'b1, 1'b0);
		send(INTERVAL_INVALID, 16'd1000, 1'b0, 1'b0);
		set_windows(10, 20, 30, 40);
		send(8'd10, 16'd5000, 1'b1, 1'b0);
		send(8'd10, 16'd4990, 1'b0, 1'b0);
		send(8'd10, RAIN_INVALID, 1'b0, 1'b0);
		send(8'd10, 16'd4900, 1'b0, 1'b0);
		send(8'd10, 16'd4000, 1'b0, 1'b1);
		send(8'd25, RAIN_INVALID, 1'b1, 1'b0);
		send(8'd25, 16'd100, 1'b0, 1'b1);
		send(8'd30, 16'd5, 1'b1, 1'b0);
		send(8'd0, 16'd10, 1'b0, 1'b1);
	endtask

	task automatic test_threshold_extremes();
		set_windows(0, 0, 0, 0);
		repeat (10) send_walk($urandom_range(1, 3));
		set_windows(65535, 65535, 65535, 65535);
		interval_max = 254;
		repeat (8) send_walk($urandom_range(1, 5));
	endtask

	task automatic test_elapsed_wrap();
		logic [RAIN_W-1:0] rain_now;
		set_windows(50, 100, 65000, 65535);
		rain_now = RAIN_W'($urandom_range(0, 65535));
		for (int i = 0; i < 280; i++) begin
			send(8'd240, rain_now, i == 0, i == 279);
			rain_now = rain_now - RAIN_W'($urandom_range(0, 3));
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		gap_max = 0;
		hold_request = 300;
		repeat (60) send_walk(1);
		// pause until the last result has drained
		wait_idle();
		gap_max = 5;
	endtask

	task automatic test_random_walks();
		int target;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase % 3 == 2) begin
				set_windows($urandom_range(0, 3000), $urandom_range(0, 3000),
					$urandom_range(0, 3000), $urandom_range(0, 3000));
			end else begin
				windows.hour = MIN_W'($urandom_range(0, 200));
				windows.day = windows.hour + MIN_W'($urandom_range(0, 400));
				windows.week = windows.day + MIN_W'($urandom_range(0, 800));
				windows.month = windows.week + MIN_W'($urandom_range(0, 1500));
				set_windows(windows.hour, windows.day, windows.week, windows.month);
			end
			interval_max = windows.month / 10;
			if (interval_max < 1) interval_max = 1;
			if (interval_max > 254) interval_max = 254;
			gap_max = $urandom_range(0, 6);
			target = records_walked + 75;
			while (records_walked < target)
				send_walk(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 12));
		end
	endtask

	initial begin
		walk = '0;
		windows = '{HOUR_RESET, DAY_RESET, WEEK_RESET, MONTH_RESET};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_threshold_extremes();
		test_elapsed_wrap();
		test_backpressure();
		test_random_walks();
		wait_idle();
		repeat (10) @(posedge clk);
		if (errors_seen == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/rpt_pkg.sv
hdl/rpt_step.sv
hdl/rain_period_totalizer.sv
tb/sv/rain_period_totalizer_tb.sv
